>>> hw/rtl/kpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kpc_pkg;

   localparam int CsrIndexBits = 2;
   localparam int CsrDataBits  = 8;

   localparam logic [CsrIndexBits-1:0] CSR_PIN_ENABLE      = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_LONG_TICKS      = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_REPEAT_INTERVAL = 2'd2;
   localparam logic [CsrIndexBits-1:0] CSR_MIN_TIME        = 2'd3;

   localparam logic [7:0] PIN_ENABLE_RESET      = 8'hFF;
   localparam logic [6:0] LONG_TICKS_RESET      = 7'd32;
   localparam logic [6:0] REPEAT_INTERVAL_RESET = 7'd1;
   localparam logic [6:0] MIN_TIME_RESET        = 7'd2;

   typedef enum logic [1:0] {
      EV_LONG,
      EV_REPEAT,
      EV_RELEASE_LONG,
      EV_SHORT
   } event_kind_type;

   typedef struct packed {
      logic [7:0] pin_enable;
      logic [6:0] long_ticks;
      logic [6:0] repeat_interval;
      logic [6:0] min_time;
   } cfg_type;

endpackage

`default_nettype wire

>>> hw/rtl/key_press_classifier_core.sv
// Channel   Direction  Payload                          Handshake
// req       in         req_port_pins[7:0]               req_valid / req_stall
// rsp       out        rsp_key_code[7:0], rsp_event_kind rsp_valid / rsp_stall
// csr       in         csr_index[1:0], csr_write_data    csr_write_enable
//
// One scan tick per cycle while req_stall is low: the hold state and the
// result register are both updated at the edge that accepts the request,
// so throughput is one per clock; a result appears on rsp in the cycle
// after its request is accepted. Reset is synchronous; it clears the hold
// state, the result valid and restores the register defaults.
// req_stall is raised only while a result is held by rsp_stall.
`timescale 1ns / 1ps
`default_nettype none

module key_press_classifier_core #(
   parameter int KEY_BITS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [7:0]                        req_port_pins,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [7:0]                             rsp_key_code,
   output logic [1:0]                             rsp_event_kind,
   input  wire logic                              csr_write_enable,
   input  wire logic [kpc_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [kpc_pkg::CsrDataBits-1:0]  csr_write_data
);
   import kpc_pkg::*;

   localparam logic [7:0] PinMask = 8'((16'd1 << KEY_BITS) - 16'd1);

   cfg_type cfg;

   logic [7:0]     prev_sample_ff, prev_sample_in;
   logic [7:0]     last_pattern_ff, last_pattern_in;
   logic [7:0]     hold_count_ff, hold_count_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_code_ff, rsp_code_in;
   event_kind_type rsp_kind_ff, rsp_kind_in;

   logic       accept;
   logic [7:0] sample;
   logic [7:0] pattern;
   logic [7:0] count_inc;
   logic [7:0] repeat_limit;
   logic       emit;
   logic [7:0] emit_code;
   event_kind_type emit_kind;

   kpc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign sample       = ~req_port_pins & cfg.pin_enable & PinMask;
   assign pattern      = sample & prev_sample_ff;
   assign count_inc    = hold_count_ff + 8'd1;
   assign repeat_limit = {1'b0, cfg.long_ticks} + {1'b0, cfg.repeat_interval};

   always_comb begin
      hold_count_in = hold_count_ff;
      emit          = 1'b0;
      emit_code     = pattern;
      emit_kind     = EV_LONG;
      if (pattern != 8'd0) begin
         if (pattern == last_pattern_ff) begin
            hold_count_in = count_inc;
            priority if (count_inc == {1'b0, cfg.long_ticks}) begin
               emit = 1'b1;
            end else if (count_inc >= repeat_limit) begin
               hold_count_in = {1'b0, cfg.long_ticks};
               emit          = 1'b1;
               emit_kind     = EV_REPEAT;
            end
         end else begin
            hold_count_in = 8'd0;
         end
      end else begin
         emit_code = last_pattern_ff;
         if (last_pattern_ff != 8'd0) begin
            priority if (hold_count_ff >= {1'b0, cfg.long_ticks}) begin
               emit      = 1'b1;
               emit_kind = EV_RELEASE_LONG;
            end else if (hold_count_ff > {1'b0, cfg.min_time}) begin
               emit      = 1'b1;
               emit_kind = EV_SHORT;
            end
         end
         hold_count_in = 8'd0;
      end
   end

   always_comb begin
      prev_sample_in  = prev_sample_ff;
      last_pattern_in = last_pattern_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_code_in     = rsp_code_ff;
      rsp_kind_in     = rsp_kind_ff;
      if (accept) begin
         prev_sample_in  = sample;
         last_pattern_in = pattern;
         rsp_valid_in    = emit;
         rsp_code_in     = emit_code;
         rsp_kind_in     = emit_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff  <= 8'd0;
         last_pattern_ff <= 8'd0;
         hold_count_ff   <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         prev_sample_ff  <= prev_sample_in;
         last_pattern_ff <= last_pattern_in;
         if (accept) begin
            hold_count_ff <= hold_count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_code   = rsp_code_ff;
   assign rsp_event_kind = rsp_kind_ff;

endmodule

`default_nettype wire

>>> hw/rtl/kpc_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module kpc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [kpc_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [kpc_pkg::CsrDataBits-1:0]  csr_write_data,
   output kpc_pkg::cfg_type                       cfg
);
   import kpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PIN_ENABLE:      cfg_in.pin_enable      = csr_write_data;
            CSR_LONG_TICKS:      cfg_in.long_ticks      = csr_write_data[6:0];
            CSR_REPEAT_INTERVAL: cfg_in.repeat_interval = csr_write_data[6:0];
            CSR_MIN_TIME:        cfg_in.min_time        = csr_write_data[6:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_enable      <= PIN_ENABLE_RESET;
         cfg_ff.long_ticks      <= LONG_TICKS_RESET;
         cfg_ff.repeat_interval <= REPEAT_INTERVAL_RESET;
         cfg_ff.min_time        <= MIN_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hw/rtl/kpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kpc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_key_code,
   input wire logic [1:0] rsp_event_kind
);

   // A held result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_code)
                                 && $stable(rsp_event_kind))
      else $error("rsp payload changed while stalled");

   // No new request may be taken while a result is stuck at the output.
   a_req_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request accepted over a stalled result");

   // Without an accepted request no new result can appear.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall) && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("result without a request");

   // Every event refers to at least one key.
   a_code_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_key_code != 8'd0)
      else $error("event with empty key code");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind key_press_classifier_core kpc_checker u_kpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_key_code   (rsp_key_code),
   .rsp_event_kind (rsp_event_kind)
);

`default_nettype wire

>>> test/key_press_classifier_checker.sv
`timescale 1ns / 1ps

module key_press_classifier_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire logic [7:0]                        req_port_pins,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire logic [7:0]                        rsp_key_code,
   input  wire logic [1:0]                        rsp_event_kind,
   input  wire logic                              csr_write_enable,
   input  wire logic [kpc_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [kpc_pkg::CsrDataBits-1:0]  csr_write_data,
   output int                                     fail_count,
   output int                                     pending_count
);

   import kpc_pkg::*;

   typedef struct packed {
      logic [7:0]     key_code;
      event_kind_type kind;
   } key_event_type;

   key_event_type expected_events[$];

   cfg_type    settings;
   logic [7:0] prev_sample;
   logic [7:0] held_pattern;
   logic [7:0] hold_count;

   function automatic void expect_event(input logic [7:0] code, input event_kind_type kind);
      key_event_type ev;
      ev.key_code = code;
      ev.kind     = kind;
      expected_events.push_back(ev);
   endfunction

   // One scan tick: a pattern only counts as held when it was also present on the
   // previous tick, so a single-tick press never reaches the counter.
   function automatic void classify_tick(input logic [7:0] pins);
      logic [7:0] sample;
      logic [7:0] pattern;
      sample       = ~pins & settings.pin_enable;
      pattern      = sample & prev_sample;
      prev_sample  = sample;
      if (pattern != 8'd0) begin
         if (pattern == held_pattern) begin
            hold_count = hold_count + 8'd1;
            if (hold_count == {1'b0, settings.long_ticks}) begin
               expect_event(pattern, EV_LONG);
            end else if (int'(hold_count) >=
                         int'(settings.long_ticks) + int'(settings.repeat_interval)) begin
               hold_count = {1'b0, settings.long_ticks};
               expect_event(pattern, EV_REPEAT);
            end
         end else begin
            hold_count = 8'd0;
         end
      end else begin
         if (held_pattern != 8'd0) begin
            if (hold_count >= {1'b0, settings.long_ticks}) begin
               expect_event(held_pattern, EV_RELEASE_LONG);
            end else if (hold_count > {1'b0, settings.min_time}) begin
               expect_event(held_pattern, EV_SHORT);
            end
         end
         hold_count = 8'd0;
      end
      held_pattern = pattern;
   endfunction

   always @(posedge clock) begin : watch_channels
      key_event_type oldest;
      if (reset) begin
         settings.pin_enable      = PIN_ENABLE_RESET;
         settings.long_ticks      = LONG_TICKS_RESET;
         settings.repeat_interval = REPEAT_INTERVAL_RESET;
         settings.min_time        = MIN_TIME_RESET;
         prev_sample  = 8'd0;
         held_pattern = 8'd0;
         hold_count   = 8'd0;
         expected_events.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected key event, expected none, got code %02h kind %0d",
                        $time, rsp_key_code, rsp_event_kind);
            end else begin
               oldest = expected_events.pop_front();
               if (rsp_key_code !== oldest.key_code) begin
                  fail_count++;
                  $display("%0t: key_code mismatch, expected %02h, got %02h",
                           $time, oldest.key_code, rsp_key_code);
               end
               if (rsp_event_kind !== oldest.kind) begin
                  fail_count++;
                  $display("%0t: event_kind mismatch, expected %0d (%s), got %0d",
                           $time, oldest.kind, oldest.kind.name(), rsp_event_kind);
               end
            end
         end
         if (req_valid && !req_stall) begin
            classify_tick(req_port_pins);
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PIN_ENABLE:      settings.pin_enable      = csr_write_data;
               CSR_LONG_TICKS:      settings.long_ticks      = csr_write_data[6:0];
               CSR_REPEAT_INTERVAL: settings.repeat_interval = csr_write_data[6:0];
               CSR_MIN_TIME:        settings.min_time        = csr_write_data[6:0];
               default: ;
            endcase
         end
      end
      pending_count = expected_events.size();
   end

endmodule

>>> test/tb_key_press_classifier_core.sv
`timescale 1ns / 1ps

module tb_key_press_classifier_core;

   import kpc_pkg::*;

   localparam int IdleLimit   = 1000;
   localparam int ItemTarget  = 1250;
   localparam int HoldOffSpan = 300;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   wire logic               req_stall;
   logic [7:0]              req_port_pins;
   wire logic               rsp_valid;
   logic                    rsp_stall;
   wire logic [7:0]         rsp_key_code;
   wire logic [1:0]         rsp_event_kind;
   logic                    csr_write_enable;
   logic [CsrIndexBits-1:0] csr_index;
   logic [CsrDataBits-1:0]  csr_write_data;

   int fail_count;
   int pending_count;
   int items_sent;
   int idle_cycles;
   bit hold_off_request;
   bit no_gaps;

   // Settings currently programmed, used only to shape the key sequences.
   logic [7:0] mask_now;
   int         long_now;
   int         rep_now;
   int         min_now;

   key_press_classifier_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_port_pins    (req_port_pins),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_code     (rsp_key_code),
      .rsp_event_kind   (rsp_event_kind),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   key_press_classifier_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_port_pins    (req_port_pins),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_key_code     (rsp_key_code),
      .rsp_event_kind   (rsp_event_kind),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IdleLimit) begin
            $display("key_press_classifier_core verification failed");
            $finish;
         end
      end
   end

   // Result side: random stall pattern, plus one long hold-off on request.
   initial begin : receiver
      int pick;
      int span;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         pick = $urandom_range(0, 99);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            span = HoldOffSpan;
         end else if (pick < 15) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(50, 150);
         end else if (pick < 55) begin
            rsp_stall <= 1'b0;
            span = $urandom_range(1, 20);
         end else if (pick < 90) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 3);
         end else begin
            rsp_stall <= 1'b1;
            span = $urandom_range(8, 40);
         end
         repeat (span - 1) @(negedge clock);
      end
   end

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 55) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   task automatic send_tick(input logic [7:0] pins);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_port_pins <= pins;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic hold_keys(input logic [7:0] pins, input int ticks);
      repeat (ticks) send_tick(pins);
   endtask

   // Waits until every predicted event has come back, then lets the block settle.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexBits-1:0] idx,
                                 input logic [CsrDataBits-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // The top bit of the 7-bit registers is set now and then; it must be dropped.
   function automatic logic [7:0] count_word(input int value);
      logic [7:0] word;
      word = 8'(value);
      if ($urandom_range(0, 3) == 0) word[7] = 1'b1;
      return word;
   endfunction

   task automatic apply_settings(input logic [7:0] mask, input int lc, input int ri,
                                 input int mt);
      drain_results();
      write_register(CSR_PIN_ENABLE, mask);
      write_register(CSR_LONG_TICKS, count_word(lc));
      write_register(CSR_REPEAT_INTERVAL, count_word(ri));
      write_register(CSR_MIN_TIME, count_word(mt));
      mask_now = mask;
      long_now = lc;
      rep_now  = ri;
      min_now  = mt;
   endtask

   function automatic logic [7:0] pick_keys();
      logic [7:0] keys;
      if ($urandom_range(0, 1) == 1) begin
         keys = 8'h01 << $urandom_range(0, 7);
      end else begin
         keys = 8'($urandom_range(1, 255));
      end
      if ((keys & mask_now) != 8'd0 && $urandom_range(0, 7) != 0) keys = keys & mask_now;
      return keys;
   endfunction

   // Hold lengths cluster around the thresholds that decide the event.
   function automatic int pick_hold();
      int ticks;
      case ($urandom_range(0, 3))
         0: ticks = $urandom_range(1, min_now + 3);
         1: ticks = long_now + $urandom_range(0, 2);
         2: ticks = long_now + rep_now * $urandom_range(1, 3) + $urandom_range(0, 2);
         default: ticks = $urandom_range(1, 2 * long_now + 2);
      endcase
      if (ticks > 300) ticks = 300;
      return ticks;
   endfunction

   task automatic run_sequence();
      int pick;
      pick    = $urandom_range(0, 99);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (pick < 70) begin
         hold_keys(~pick_keys(), pick_hold());
         hold_keys(8'hFF, $urandom_range(1, 3));
      end else if (pick < 85) begin
         // Switch pattern mid-hold; the old one can release only if the two share no key.
         hold_keys(~pick_keys(), pick_hold());
         hold_keys(~pick_keys(), pick_hold());
         hold_keys(8'hFF, $urandom_range(1, 3));
      end else begin
         repeat ($urandom_range(1, 6)) send_tick(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      int phase_end;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_port_pins    = 8'hFF;
      csr_write_enable = 1'b0;
      csr_index        = CSR_PIN_ENABLE;
      csr_write_data   = 8'd0;
      hold_off_request = 1'b0;
      no_gaps          = 1'b0;
      items_sent       = 0;
      idle_cycles      = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: all keys down through long press, repeat and release.
      apply_settings(8'hFF, 3, 2, 1);
      hold_keys(8'h00, 7);
      send_tick(8'hFF);
      // Short press, then a short tap that also changes pattern.
      hold_keys(8'hFE, 4);
      send_tick(8'hFF);
      hold_keys(8'hF3, 3);
      send_tick(8'hF7);
      send_tick(8'hFF);
      // Zero long count: repeats only, and the release counts as after long.
      apply_settings(8'hFF, 0, 2, 1);
      hold_keys(8'h7F, 4);
      send_tick(8'hFF);
      // Zero repeat interval behaves like one.
      apply_settings(8'hFF, 2, 0, 1);
      hold_keys(8'hBF, 5);
      send_tick(8'hFF);

      apply_settings(8'hFF, 127, 127, 127);
      repeat (3) run_sequence();

      apply_settings(8'h00, 1, 1, 0);
      phase_end = items_sent + 30;
      while (items_sent < phase_end) run_sequence();

      // An event on every held tick while the receiver holds off fills the block.
      apply_settings(8'hFF, 1, 1, 0);
      hold_off_request = 1'b1;
      no_gaps          = 1'b1;
      hold_keys(8'hE7, 120);
      hold_keys(8'hFF, 2);
      phase_end = items_sent + 80;
      while (items_sent < phase_end) run_sequence();

      while (items_sent < ItemTarget) begin
         apply_settings(($urandom_range(0, 1) == 1) ? 8'hFF : 8'($urandom_range(0, 255)),
                        ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12),
                        $urandom_range(1, 6), 0);
         min_now = $urandom_range(0, long_now + 2);
         write_register(CSR_MIN_TIME, count_word(min_now));
         phase_end = items_sent + 100;
         while (items_sent < phase_end) run_sequence();
      end

      drain_results();
      repeat (5) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("key_press_classifier_core verification clean");
      end else begin
         $display("key_press_classifier_core verification failed");
      end
      $finish;
   end

endmodule
